### rtl/lptc_pkg.sv
`timescale 1ns / 1ps
// shared types and constants of the lru page tag cache
// no dependencies; imported by lptc_cell and lru_page_tag_cache_top
package lptc_pkg;

   // fixed port widths
   localparam int PAGE_PORT_W = 32;
   localparam int IDX_PORT_W  = 6;
   localparam int CNT_W       = 32;

   // parameter defaults
   localparam int SLOTS_DEF      = 10;
   localparam int PAGE_BITS_DEF  = 32;
   localparam int STAMP_BITS_DEF = 32;

   // request codes
   localparam logic [1:0] REQ_READ  = 2'd0;
   localparam logic [1:0] REQ_WRITE = 2'd1;
   localparam logic [1:0] REQ_INVAL = 2'd2;

   // write command broadcast to the cells
   typedef struct packed {
      logic fill;     // install tag, set valid, restamp
      logic restamp;  // new stamp only
      logic clear;    // drop valid, zero stamp
   } cell_cmd_type;

   // control part of the victim scan wave
   typedef struct packed {
      logic tok;         // wave is at this link
      logic seen;        // best fields hold a candidate
      logic slot_valid;  // candidate slot held a valid page
   } scan_ctl_type;

endpackage

### rtl/lptc_cell.sv
`timescale 1ns / 1ps
// one slot of the tag cache: tag, valid, stamp, match link and scan link
// depends on lptc_pkg
module lptc_cell #(
   parameter int IDX        = 0,
   parameter int IDX_W      = 4,
   parameter int TAG_W      = 32,
   parameter int STAMP_BITS = 32
) (
   input  logic                       clock,
   input  logic                       reset,
   // lookup
   input  logic [TAG_W-1:0]           page,
   input  logic                       found_in,
   input  logic [IDX_W-1:0]           fidx_in,
   output logic                       found_out,
   output logic [IDX_W-1:0]           fidx_out,
   output logic                       match,
   // writes
   input  lptc_pkg::cell_cmd_type     cmd,
   input  logic [IDX_W-1:0]           cmd_idx,
   input  logic [TAG_W-1:0]           tag_wr,
   input  logic [STAMP_BITS-1:0]      stamp_wr,
   // victim scan
   input  lptc_pkg::scan_ctl_type     scan_in,
   input  logic [STAMP_BITS-1:0]      best_stamp_in,
   input  logic [IDX_W-1:0]           best_idx_in,
   input  logic [TAG_W-1:0]           best_tag_in,
   output lptc_pkg::scan_ctl_type     scan_out,
   output logic [STAMP_BITS-1:0]      best_stamp_out,
   output logic [IDX_W-1:0]           best_idx_out,
   output logic [TAG_W-1:0]           best_tag_out
);
   import lptc_pkg::*;

   logic [TAG_W-1:0]      tag_ff;
   logic                  valid_ff;
   logic [STAMP_BITS-1:0] stamp_ff;
   logic                  tok_ff;
   logic                  bvalid_ff;
   logic [STAMP_BITS-1:0] bstamp_ff;
   logic [IDX_W-1:0]      bidx_ff;
   logic [TAG_W-1:0]      btag_ff;
   logic                  sel;
   logic                  take;

   assign match     = valid_ff && (tag_ff == page);
   assign found_out = found_in | match;
   assign fidx_out  = found_in ? fidx_in : IDX_W'(IDX);

   assign sel  = (cmd_idx == IDX_W'(IDX));
   // strict less keeps the lower index on a tie
   assign take = !scan_in.seen || (stamp_ff < best_stamp_in);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         stamp_ff <= '0;
      end else if (sel && cmd.fill) begin
         valid_ff <= 1'b1;
         stamp_ff <= stamp_wr;
      end else if (sel && cmd.restamp) begin
         stamp_ff <= stamp_wr;
      end else if (sel && cmd.clear) begin
         valid_ff <= 1'b0;
         stamp_ff <= '0;
      end
   end

   always_ff @(posedge clock) begin
      if (sel && cmd.fill) begin
         tag_ff <= tag_wr;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff <= 1'b0;
      end else begin
         tok_ff <= scan_in.tok;
      end
   end

   always_ff @(posedge clock) begin
      if (scan_in.tok) begin
         if (take) begin
            bvalid_ff <= valid_ff;
            bstamp_ff <= stamp_ff;
            bidx_ff   <= IDX_W'(IDX);
            btag_ff   <= tag_ff;
         end else begin
            bvalid_ff <= scan_in.slot_valid;
            bstamp_ff <= best_stamp_in;
            bidx_ff   <= best_idx_in;
            btag_ff   <= best_tag_in;
         end
      end
   end

   assign scan_out.tok        = tok_ff;
   assign scan_out.seen       = 1'b1;
   assign scan_out.slot_valid = bvalid_ff;
   assign best_stamp_out      = bstamp_ff;
   assign best_idx_out        = bidx_ff;
   assign best_tag_out        = btag_ff;

endmodule

### rtl/lru_page_tag_cache_top.sv
`timescale 1ns / 1ps
// top level of the lru page tag cache: request/result ports, control, counters
// depends on lptc_pkg and lptc_cell
module lru_page_tag_cache_top #(
   parameter int SLOTS      = lptc_pkg::SLOTS_DEF,
   parameter int PAGE_BITS  = lptc_pkg::PAGE_BITS_DEF,
   parameter int STAMP_BITS = lptc_pkg::STAMP_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic [1:0]                         req_type,
   input  logic [lptc_pkg::PAGE_PORT_W-1:0]   req_page_number,
   output logic                               rsp_valid,
   output logic                               rsp_status,
   output logic                               rsp_hit,
   output logic [lptc_pkg::IDX_PORT_W-1:0]    rsp_slot_index,
   output logic                               rsp_filled,
   output logic                               rsp_evicted_valid,
   output logic [lptc_pkg::PAGE_PORT_W-1:0]   rsp_evicted_page,
   output logic [lptc_pkg::CNT_W-1:0]         rsp_hit_total,
   output logic [lptc_pkg::CNT_W-1:0]         rsp_miss_total
);
   // Fully associative page tag cache with time-stamp lru replacement.
   // An item is taken when start is high and busy is low; its result is
   // shown for exactly one cycle with rsp_valid high and must be taken then,
   // since the receiver cannot stall the block. For reads, writes,
   // invalidates and reads of the null page (all page bits set), the path
   // from acceptance to result is the lookup state across the row of slot
   // cells, then the result register. On a read miss instead, the
   // victim search is a wave that walks the cell row one slot per cycle,
   // carrying the smallest stamp seen so far (lowest slot on ties), and the
   // refill happens when the wave leaves the last cell. A new item may be
   // accepted in the same cycle that the previous result is shown. The
   // stamp counter wraps; the hit and miss totals saturate at all ones.
   // There is no clearing pass after reset.
   import lptc_pkg::*;

   localparam int IDX_W      = $clog2(SLOTS);
   localparam int TAG_W      = (PAGE_BITS < PAGE_PORT_W) ? PAGE_BITS : PAGE_PORT_W;
   localparam bit NULL_CHECK = (PAGE_BITS <= PAGE_PORT_W);

   // controller states
   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_LOOK = 2'd1;
   localparam logic [1:0] ST_SCAN = 2'd2;

   logic [1:0]            state_ff, state_in;
   logic [1:0]            rtype_ff;
   logic [TAG_W-1:0]      page_ff;
   logic                  null_ff;
   logic [STAMP_BITS-1:0] stamp_ff, stamp_in;
   logic [CNT_W-1:0]      hits_ff, hits_in;
   logic [CNT_W-1:0]      misses_ff, misses_in;

   // result register
   logic                  rvalid_ff, rvalid_in;
   logic                  rstatus_ff, rstatus_in;
   logic                  rhit_ff, rhit_in;
   logic [IDX_W-1:0]      rslot_ff, rslot_in;
   logic                  rfilled_ff, rfilled_in;
   logic                  revalid_ff, revalid_in;
   logic [TAG_W-1:0]      repage_ff, repage_in;

   // cell row links
   logic                  found_chain [SLOTS+1];
   logic [IDX_W-1:0]      fidx_chain  [SLOTS+1];
   scan_ctl_type          sctl_chain  [SLOTS+1];
   logic [STAMP_BITS-1:0] bstamp_chain[SLOTS+1];
   logic [IDX_W-1:0]      bidx_chain  [SLOTS+1];
   logic [TAG_W-1:0]      btag_chain  [SLOTS+1];
   logic [SLOTS-1:0]      match_vec;

   cell_cmd_type          cmd;
   logic [IDX_W-1:0]      cmd_idx;
   logic                  scan_go;
   logic                  accept;
   logic                  found;
   logic [IDX_W-1:0]      fidx;
   logic                  scan_done;
   logic [STAMP_BITS-1:0] stamp_next;

   assign accept     = start && !busy;
   assign busy       = (state_ff != ST_IDLE);
   assign found      = found_chain[SLOTS];
   assign fidx       = fidx_chain[SLOTS];
   assign scan_done  = (state_ff == ST_SCAN) && sctl_chain[SLOTS].tok;
   assign stamp_next = stamp_ff + STAMP_BITS'(1);

   // head of the row: nothing found, no candidate yet
   assign found_chain[0]           = 1'b0;
   assign fidx_chain[0]            = '0;
   assign sctl_chain[0].tok        = scan_go;
   assign sctl_chain[0].seen       = 1'b0;
   assign sctl_chain[0].slot_valid = 1'b0;
   assign bstamp_chain[0]          = '0;
   assign bidx_chain[0]            = '0;
   assign btag_chain[0]            = '0;

   for (genvar g = 0; g < SLOTS; g++) begin : g_cell
      lptc_cell #(
         .IDX        (g),
         .IDX_W      (IDX_W),
         .TAG_W      (TAG_W),
         .STAMP_BITS (STAMP_BITS)
      ) u_cell (
         .clock          (clock),
         .reset          (reset),
         .page           (page_ff),
         .found_in       (found_chain[g]),
         .fidx_in        (fidx_chain[g]),
         .found_out      (found_chain[g+1]),
         .fidx_out       (fidx_chain[g+1]),
         .match          (match_vec[g]),
         .cmd            (cmd),
         .cmd_idx        (cmd_idx),
         .tag_wr         (page_ff),
         .stamp_wr       (stamp_next),
         .scan_in        (sctl_chain[g]),
         .best_stamp_in  (bstamp_chain[g]),
         .best_idx_in    (bidx_chain[g]),
         .best_tag_in    (btag_chain[g]),
         .scan_out       (sctl_chain[g+1]),
         .best_stamp_out (bstamp_chain[g+1]),
         .best_idx_out   (bidx_chain[g+1]),
         .best_tag_out   (btag_chain[g+1])
      );
   end

   // control, counters and result staging
   always_comb begin
      state_in   = state_ff;
      stamp_in   = stamp_ff;
      hits_in    = hits_ff;
      misses_in  = misses_ff;
      cmd        = '0;
      cmd_idx    = fidx;
      scan_go    = 1'b0;
      rvalid_in  = 1'b0;
      rstatus_in = 1'b0;
      rhit_in    = 1'b0;
      rslot_in   = '0;
      rfilled_in = 1'b0;
      revalid_in = 1'b0;
      repage_in  = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_LOOK;
            end
         end
         ST_LOOK: begin
            state_in  = ST_IDLE;
            rvalid_in = 1'b1;
            case (rtype_ff)
               REQ_READ: begin
                  if (null_ff) begin
                     rstatus_in = 1'b1;
                  end else if (found) begin
                     rhit_in     = 1'b1;
                     rslot_in    = fidx;
                     cmd.restamp = 1'b1;
                     stamp_in    = stamp_next;
                     if (hits_ff != '1) begin
                        hits_in = hits_ff + CNT_W'(1);
                     end
                  end else begin
                     // miss: launch the victim wave, result comes later
                     state_in  = ST_SCAN;
                     rvalid_in = 1'b0;
                     scan_go   = 1'b1;
                     if (misses_ff != '1) begin
                        misses_in = misses_ff + CNT_W'(1);
                     end
                  end
               end
               REQ_WRITE: begin
                  if (found) begin
                     rhit_in     = 1'b1;
                     rslot_in    = fidx;
                     cmd.restamp = 1'b1;
                     stamp_in    = stamp_next;
                  end
               end
               REQ_INVAL: begin
                  if (found) begin
                     rhit_in   = 1'b1;
                     rslot_in  = fidx;
                     cmd.clear = 1'b1;
                  end
               end
               default: begin
                  // unused code: plain ok result, no change
               end
            endcase
         end
         ST_SCAN: begin
            cmd_idx = bidx_chain[SLOTS];
            if (scan_done) begin
               state_in   = ST_IDLE;
               cmd.fill   = 1'b1;
               stamp_in   = stamp_next;
               rvalid_in  = 1'b1;
               rslot_in   = bidx_chain[SLOTS];
               rfilled_in = 1'b1;
               revalid_in = sctl_chain[SLOTS].slot_valid;
               repage_in  = sctl_chain[SLOTS].slot_valid ? btag_chain[SLOTS] : '0;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         stamp_ff  <= '0;
         hits_ff   <= '0;
         misses_ff <= '0;
         rvalid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         stamp_ff  <= stamp_in;
         hits_ff   <= hits_in;
         misses_ff <= misses_in;
         rvalid_ff <= rvalid_in;
      end
   end

   // request capture
   always_ff @(posedge clock) begin
      if (accept) begin
         rtype_ff <= req_type;
         page_ff  <= req_page_number[TAG_W-1:0];
         null_ff  <= NULL_CHECK && (&req_page_number[TAG_W-1:0]);
      end
   end

   // result payload, loaded with the strobe
   always_ff @(posedge clock) begin
      if (rvalid_in) begin
         rstatus_ff <= rstatus_in;
         rhit_ff    <= rhit_in;
         rslot_ff   <= rslot_in;
         rfilled_ff <= rfilled_in;
         revalid_ff <= revalid_in;
         repage_ff  <= repage_in;
      end
   end

   assign rsp_valid         = rvalid_ff;
   assign rsp_status        = rstatus_ff;
   assign rsp_hit           = rhit_ff;
   assign rsp_slot_index    = IDX_PORT_W'(rslot_ff);
   assign rsp_filled        = rfilled_ff;
   assign rsp_evicted_valid = revalid_ff;
   assign rsp_evicted_page  = PAGE_PORT_W'(repage_ff);
   assign rsp_hit_total     = hits_ff;
   assign rsp_miss_total    = misses_ff;

   // a page sits in at most one valid slot
   a_single_match: assert property (@(posedge clock) disable iff (reset)
      $onehot0(match_vec))
      else $error("page matches more than one slot");

   // a result never shows while an item is in work
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result strobe while busy");

   // an accepted item always goes to the lookup cycle
   a_accept_look: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == ST_LOOK))
      else $error("accepted item did not enter lookup");

   // a refill is never a hit and never an error
   a_fill_kind: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_filled) |-> (!rsp_hit && !rsp_status))
      else $error("refill result marked hit or error");

   // the victim wave only ends while scanning
   a_wave_scan: assert property (@(posedge clock) disable iff (reset)
      sctl_chain[SLOTS].tok |-> (state_ff == ST_SCAN))
      else $error("victim wave outside scan");

endmodule

### bench/tb_lru_page_tag_cache_top.sv
`timescale 1ns / 1ps
// self-checking testbench of lru_page_tag_cache_top: read, write and invalidate
// items checked against a built-in lru tag predictor; needs lptc_pkg and the rtl
module tb_lru_page_tag_cache_top;

   import lptc_pkg::*;

   localparam int SLOTS      = SLOTS_DEF;
   localparam int PAGE_BITS  = PAGE_BITS_DEF;
   localparam int STAMP_BITS = STAMP_BITS_DEF;

   // request code the block must ignore
   localparam logic [1:0] REQ_UNUSED = 2'd3;

   localparam logic [PAGE_PORT_W-1:0] PAGE_MASK = {PAGE_PORT_W{1'b1}} >> (PAGE_PORT_W - PAGE_BITS);
   localparam logic [PAGE_PORT_W-1:0] RSVD_PAGE = PAGE_MASK;

   localparam int IDLE_LIMIT  = 5000;  // cycles with no item moving either way
   localparam int SETTLE      = 60;    // quiet cycles after the last result

   typedef struct {
      logic [1:0]             kind;
      logic [PAGE_PORT_W-1:0] page;
      bit                     drain;  // hold off until every result is back
   } page_req_type;

   typedef struct {
      logic                   status;
      logic                   hit;
      logic [IDX_PORT_W-1:0]  slot;
      logic                   filled;
      logic                   ev_valid;
      logic [PAGE_PORT_W-1:0] ev_page;
      logic [CNT_W-1:0]       hit_total;
      logic [CNT_W-1:0]       miss_total;
   } lookup_rsp_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   start = 1'b0;
   logic                   busy;
   logic [1:0]             req_type = REQ_READ;
   logic [PAGE_PORT_W-1:0] req_page_number = '0;
   logic                   rsp_valid;
   logic                   rsp_status;
   logic                   rsp_hit;
   logic [IDX_PORT_W-1:0]  rsp_slot_index;
   logic                   rsp_filled;
   logic                   rsp_evicted_valid;
   logic [PAGE_PORT_W-1:0] rsp_evicted_page;
   logic [CNT_W-1:0]       rsp_hit_total;
   logic [CNT_W-1:0]       rsp_miss_total;

   page_req_type   pending_reqs[$];
   lookup_rsp_type expected_rsps[$];
   int             error_count = 0;

   // predictor copy of the cache state
   logic [PAGE_PORT_W-1:0] tag_copy   [SLOTS];
   logic                   valid_copy [SLOTS];
   logic [STAMP_BITS-1:0]  stamp_copy [SLOTS];
   logic [STAMP_BITS-1:0]  stamp_clock;
   logic [CNT_W-1:0]       hit_count;
   logic [CNT_W-1:0]       miss_count;

   lru_page_tag_cache_top u_top (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_type          (req_type),
      .req_page_number   (req_page_number),
      .rsp_valid         (rsp_valid),
      .rsp_status        (rsp_status),
      .rsp_hit           (rsp_hit),
      .rsp_slot_index    (rsp_slot_index),
      .rsp_filled        (rsp_filled),
      .rsp_evicted_valid (rsp_evicted_valid),
      .rsp_evicted_page  (rsp_evicted_page),
      .rsp_hit_total     (rsp_hit_total),
      .rsp_miss_total    (rsp_miss_total)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic report_mismatch(input string msg);
      error_count++;
      $display("%0t ns: mismatch: %s", $time, msg);
   endtask

   task automatic check_field(input string name, input logic [63:0] got,
                              input logic [63:0] want);
      if (got !== want) begin
         report_mismatch($sformatf("%s got 0x%0h expected 0x%0h", name, got, want));
      end
   endtask

   // work out the result of one accepted item and advance the state copy
   task automatic predict_tag_access(input logic [1:0] kind,
                                     input logic [PAGE_PORT_W-1:0] page_in);
      lookup_rsp_type         rsp;
      logic [PAGE_PORT_W-1:0] page;
      int                     match;
      int                     victim;
      rsp = '{default: '0};
      page = page_in & PAGE_MASK;
      match = -1;
      for (int i = 0; i < SLOTS; i++) begin
         if (match < 0 && valid_copy[i] && tag_copy[i] == page) match = i;
      end
      case (kind)
         REQ_READ: begin
            // null page read is an error and touches nothing
            if (page == RSVD_PAGE) begin
               rsp.status = 1'b1;
            end else if (match >= 0) begin
               rsp.hit  = 1'b1;
               rsp.slot = match[IDX_PORT_W-1:0];
               if (hit_count != '1) hit_count++;
               stamp_clock++;
               stamp_copy[match] = stamp_clock;
            end else begin
               // oldest raw stamp wins, lowest index on ties
               victim = 0;
               for (int i = 1; i < SLOTS; i++) begin
                  if (stamp_copy[i] < stamp_copy[victim]) victim = i;
               end
               if (miss_count != '1) miss_count++;
               rsp.slot   = victim[IDX_PORT_W-1:0];
               rsp.filled = 1'b1;
               if (valid_copy[victim]) begin
                  rsp.ev_valid = 1'b1;
                  rsp.ev_page  = tag_copy[victim];
               end
               tag_copy[victim]   = page;
               valid_copy[victim] = 1'b1;
               stamp_clock++;
               stamp_copy[victim] = stamp_clock;
            end
         end
         REQ_WRITE: begin
            if (match >= 0) begin
               rsp.hit  = 1'b1;
               rsp.slot = match[IDX_PORT_W-1:0];
               stamp_clock++;
               stamp_copy[match] = stamp_clock;
            end
         end
         REQ_INVAL: begin
            if (match >= 0) begin
               rsp.hit  = 1'b1;
               rsp.slot = match[IDX_PORT_W-1:0];
               valid_copy[match] = 1'b0;
               stamp_copy[match] = '0;
            end
         end
         default: ;  // unused code: plain ok result, no state change
      endcase
      rsp.hit_total  = hit_count;
      rsp.miss_total = miss_count;
      expected_rsps.push_back(rsp);
   endtask

   task automatic add_req(input logic [1:0] kind, input logic [PAGE_PORT_W-1:0] page,
                          input bit drain);
      page_req_type r;
      r.kind  = kind;
      r.page  = page;
      r.drain = drain;
      pending_reqs.push_back(r);
   endtask

   // driver: sends items in bursts with random gaps between them
   int burst_left = 1;
   int gap_left   = 0;

   always @(posedge clock) begin
      page_req_type nxt;
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            // item taken at this edge, the ports still hold it
            predict_tag_access(req_type, req_page_number);
            burst_left--;
            if (burst_left <= 0) begin
               burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                        : $urandom_range(1, 15);
               gap_left   = $urandom_range(1, 12);
            end
         end
         if (start && busy) begin
            // hold the item until the block takes it
         end else if (gap_left > 0) begin
            gap_left--;
            start <= 1'b0;
         end else if (pending_reqs.size() > 0 &&
                      (!pending_reqs[0].drain || expected_rsps.size() == 0)) begin
            nxt = pending_reqs.pop_front();
            start           <= 1'b1;
            req_type        <= nxt.kind;
            req_page_number <= nxt.page;
         end else begin
            start <= 1'b0;
         end
      end
   end

   // monitor: every strobed result is checked against the oldest expectation
   always @(posedge clock) begin
      lookup_rsp_type want;
      if (!reset && rsp_valid) begin
         if (expected_rsps.size() == 0) begin
            report_mismatch("result with no item outstanding");
         end else begin
            want = expected_rsps.pop_front();
            check_field("status",        rsp_status,        want.status);
            check_field("hit",           rsp_hit,           want.hit);
            check_field("slot_index",    rsp_slot_index,    want.slot);
            check_field("filled",        rsp_filled,        want.filled);
            check_field("evicted_valid", rsp_evicted_valid, want.ev_valid);
            check_field("evicted_page",  rsp_evicted_page,  want.ev_page);
            check_field("hit_total",     rsp_hit_total,     want.hit_total);
            check_field("miss_total",    rsp_miss_total,    want.miss_total);
         end
      end
   end

   // watchdog: too long with no item accepted on either side
   int idle_cycles = 0;

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("tb_lru_page_tag_cache_top: FAIL");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      logic [PAGE_PORT_W-1:0] pool[24];
      logic [PAGE_PORT_W-1:0] page;
      logic [1:0]             kind;
      int                     pool_size;
      int                     pick;

      // predictor reset state; tags are only read while valid
      for (int i = 0; i < SLOTS; i++) begin
         tag_copy[i]   = '0;
         valid_copy[i] = 1'b0;
         stamp_copy[i] = '0;
      end
      stamp_clock = '0;
      hit_count   = '0;
      miss_count  = '0;

      // directed part
      add_req(REQ_READ,  32'h0000_0000, 1'b0);  // miss into an empty slot
      add_req(REQ_READ,  32'h0000_0000, 1'b0);  // hit
      add_req(REQ_READ,  32'hFFFF_FFFE, 1'b0);  // largest real page
      add_req(REQ_READ,  RSVD_PAGE,     1'b0);  // null page read: error
      add_req(REQ_WRITE, RSVD_PAGE,     1'b0);  // null page write never matches
      add_req(REQ_INVAL, RSVD_PAGE,     1'b0);  // same for invalidate
      add_req(REQ_WRITE, 32'h0000_0000, 1'b0);  // write hit restamps
      add_req(REQ_WRITE, 32'h1234_5678, 1'b0);  // write miss does nothing
      add_req(REQ_INVAL, 32'hFFFF_FFFE, 1'b0);  // invalidate hit zeroes the stamp
      add_req(REQ_INVAL, 32'hFFFF_FFFE, 1'b0);  // now it misses
      add_req(REQ_UNUSED, 32'h0000_0000, 1'b0); // ignored code
      add_req(REQ_UNUSED, RSVD_PAGE,    1'b0);
      // fill the rest, then evict valid pages in lru order
      for (int i = 0; i < 12; i++) begin
         add_req(REQ_READ, 32'h8000_0000 ^ (i * 32'h0101_0101), 1'b0);
      end

      // random part: phases over a working set of varying size
      for (int ph = 0; ph < 6; ph++) begin
         pool_size = $urandom_range(3, 24);
         for (int i = 0; i < 24; i++) begin
            pool[i] = $urandom();
            if (pool[i] == RSVD_PAGE) pool[i] = pool[i] ^ 32'h1;
         end
         for (int n = 0; n < 102; n++) begin
            // slow churn of the working set
            if ($urandom_range(0, 19) == 0) begin
               pool[$urandom_range(0, pool_size - 1)] = $urandom() & ~32'h1;
            end
            pick = $urandom_range(0, 99);
            if (pick < 55)      kind = REQ_READ;
            else if (pick < 75) kind = REQ_WRITE;
            else if (pick < 96) kind = REQ_INVAL;
            else                kind = REQ_UNUSED;
            pick = $urandom_range(0, 99);
            if (pick < 85)      page = pool[$urandom_range(0, pool_size - 1)];
            else if (pick < 90) page = RSVD_PAGE;
            else                page = $urandom();
            // first item of each phase waits for the block to drain
            add_req(kind, page, n == 0);
         end
      end

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      do @(posedge clock);
      while (pending_reqs.size() > 0 || start || expected_rsps.size() > 0);
      repeat (SETTLE) @(posedge clock);

      if (error_count == 0) begin
         $display("tb_lru_page_tag_cache_top: PASS");
      end else begin
         $display("tb_lru_page_tag_cache_top: FAIL");
      end
      $finish;
   end

endmodule
